// File: sv/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg: shared types and codes of the complex arithmetic unit
// Operation classes, mode codes, status codes and the back-end state type.
// ----------------------------------------------------------------------------
package cau_pkg;

  // operation class decided by the front end
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_DIVZ,
    OP_CMP,
    OP_NONE
  } op_e;

  // mode codes on the input channel
  localparam logic [3:0] MODE_ADD = 4'd0;
  localparam logic [3:0] MODE_SUB = 4'd1;
  localparam logic [3:0] MODE_MUL = 4'd2;
  localparam logic [3:0] MODE_DIV = 4'd3;
  localparam logic [3:0] MODE_EQ  = 4'd4;
  localparam logic [3:0] MODE_NE  = 4'd5;
  localparam logic [3:0] MODE_LE  = 4'd6;
  localparam logic [3:0] MODE_GE  = 4'd7;
  localparam logic [3:0] MODE_LT  = 4'd8;
  localparam logic [3:0] MODE_GT  = 4'd9;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DSET,
    BK_DRUN,
    BK_DFIN
  } bk_state_e;

endpackage
`default_nettype wire

// File: sv/cau_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_if: channel interfaces of the complex arithmetic unit
// Operand channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface cau_in_if #(parameter int WORD_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic [3:0]                   mode;
  logic signed [WORD_WIDTH-1:0] a_re;
  logic signed [WORD_WIDTH-1:0] a_im;
  logic signed [WORD_WIDTH-1:0] b_re;
  logic signed [WORD_WIDTH-1:0] b_im;

  modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int WORD_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] out_re;
  logic signed [WORD_WIDTH-1:0] out_im;
  logic                         compare_true;
  logic [1:0]                   status;

  modport source (output valid, out_re, out_im, compare_true, status, input ready);
  modport sink   (input valid, out_re, out_im, compare_true, status, output ready);
endinterface
`default_nettype wire

// File: sv/cau_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front: operand intake and classification
// Takes operand transfers, decodes the mode into an operation class (flagging
// a zero divisor up front) and pushes the item into the queue.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int WORD_WIDTH = 32,
  parameter int ITEM_W     = 3 + 4 + 4 * 32
) (
  cau_in_if.sink              in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output logic [ITEM_W-1:0]   push_data_o
);
  import cau_pkg::*;

  typedef struct packed {
    op_e                          op;
    logic [3:0]                   mode;
    logic signed [WORD_WIDTH-1:0] a_re;
    logic signed [WORD_WIDTH-1:0] a_im;
    logic signed [WORD_WIDTH-1:0] b_re;
    logic signed [WORD_WIDTH-1:0] b_im;
  } item_t;

  item_t item;
  op_e   op;
  logic  b_zero;

  // zero divisor is caught here so the back end never starts a division on it
  assign b_zero = (in_i.b_re == '0) && (in_i.b_im == '0);

  // mode decode
  always_comb begin
    case (in_i.mode)
      MODE_ADD: op = OP_ADD;
      MODE_SUB: op = OP_SUB;
      MODE_MUL: op = OP_MUL;
      MODE_DIV: op = b_zero ? OP_DIVZ : OP_DIV;
      default: begin
        if (in_i.mode inside {[MODE_EQ:MODE_GT]}) op = OP_CMP;
        else op = OP_NONE;
      end
    endcase
  end

  always_comb begin
    item.op   = op;
    item.mode = in_i.mode;
    item.a_re = in_i.a_re;
    item.a_im = in_i.a_im;
    item.b_re = in_i.b_re;
    item.b_im = in_i.b_im;
  end

  assign push_data_o  = ITEM_W'(item);
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule
`default_nettype wire

// File: sv/cau_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_queue: short queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module cau_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  ap_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule
`default_nettype wire

// File: sv/cau_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back: execution back end
// Add, subtract, compare from the popped item; multiply via a registered
// product stage and sum/clamp; divide via it, a setup stage and a restoring
// divider retiring one quotient bit per cycle for real and imaginary together.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int ITEM_W     = 3 + 4 + 4 * 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  logic [ITEM_W-1:0] pop_data_i,
  cau_out_if.source         out_o
);
  import cau_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 1;
  localparam int NW = 2 * W + FRAC_BITS;
  localparam int QB = W + 1;
  localparam int CW = (NW > 3 * W + 1) ? NW : 3 * W + 1;
  localparam int KW = $clog2(QB + 1);

  localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    op_e                  op;
    logic [3:0]           mode;
    logic signed [W-1:0]  a_re;
    logic signed [W-1:0]  a_im;
    logic signed [W-1:0]  b_re;
    logic signed [W-1:0]  b_im;
  } item_t;

  // clamp a wide signed value to the word range; top bit flags a clamp
  function automatic logic [W:0] sat_f(input logic signed [XW-1:0] x);
    logic [W:0] r;
    if (x > XW'(MAX_W)) r = {1'b1, MAX_W};
    else if (x < XW'(MIN_W)) r = {1'b1, MIN_W};
    else r = {1'b0, x[W-1:0]};
    return r;
  endfunction

  item_t     it;
  bk_state_e state_q, state_d;
  logic      simple, out_free, pop, load;

  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_br2_q, p_bi2_q;
  logic [CW-1:0]        rem_re_q, rem_re_d, rem_im_q, rem_im_d, dsh_q, dsh_d;
  logic [QB-1:0]        q_re_q, q_re_d, q_im_q, q_im_d;
  logic                 neg_re_q, neg_re_d, neg_im_q, neg_im_d;
  logic                 ovp_re_q, ovp_re_d, ovp_im_q, ovp_im_d;
  logic [KW-1:0]        cnt_q, cnt_d;

  logic                 out_valid_q, out_valid_d, out_cmp_q, out_cmp_d;
  logic signed [W-1:0]  out_re_q, out_re_d, out_im_q, out_im_d;
  logic [1:0]           out_st_q, out_st_d;

  logic signed [XW-1:0] x_re, x_im, qe_re, qe_im;
  logic [W:0]           s_re, s_im;
  logic [PW-1:0]        mag_re, mag_im, den;
  logic [CW-1:0]        n_re, n_im, den_top;
  logic                 ge_re, ge_im, cmp;

  assign it       = item_t'(pop_data_i);
  assign out_free = !out_valid_q || out_o.ready;
  assign simple   = (it.op != OP_MUL) && (it.op != OP_DIV);
  assign pop      = (state_q == BK_IDLE) && pop_valid_i && (!simple || out_free);
  assign pop_ready_o = pop;

  // part-wise compare for the comparison modes
  always_comb begin
    case (it.mode)
      MODE_EQ: cmp = (it.a_re == it.b_re) && (it.a_im == it.b_im);
      MODE_NE: cmp = (it.a_re != it.b_re) || (it.a_im != it.b_im);
      MODE_LE: cmp = (it.a_re <= it.b_re) && (it.a_im <= it.b_im);
      MODE_GE: cmp = (it.a_re >= it.b_re) && (it.a_im >= it.b_im);
      MODE_LT: cmp = (it.a_re <  it.b_re) && (it.a_im <  it.b_im);
      MODE_GT: cmp = (it.a_re >  it.b_re) && (it.a_im >  it.b_im);
      default: cmp = 1'b0;
    endcase
  end

  // product stage: all partial products for multiply and divide
  always_ff @(posedge clk_i) begin
    if (pop) begin
      p_rr_q  <= PW'(it.a_re) * PW'(it.b_re);
      p_ii_q  <= PW'(it.a_im) * PW'(it.b_im);
      p_ri_q  <= PW'(it.a_re) * PW'(it.b_im);
      p_ir_q  <= PW'(it.a_im) * PW'(it.b_re);
      p_br2_q <= PW'(it.b_re) * PW'(it.b_re);
      p_bi2_q <= PW'(it.b_im) * PW'(it.b_im);
    end
  end

  // divide setup values: numerators, magnitudes, denominator
  always_comb begin
    x_re    = XW'(p_rr_q) + XW'(p_ii_q);
    x_im    = XW'(p_ir_q) - XW'(p_ri_q);
    mag_re  = x_re[XW-1] ? PW'(-x_re) : PW'(x_re);
    mag_im  = x_im[XW-1] ? PW'(-x_im) : PW'(x_im);
    den     = $unsigned(p_br2_q) + $unsigned(p_bi2_q);
    n_re    = CW'(mag_re) << FRAC_BITS;
    n_im    = CW'(mag_im) << FRAC_BITS;
    den_top = CW'(den) << QB;
  end

  // restoring divider step
  assign ge_re = (rem_re_q >= dsh_q);
  assign ge_im = (rem_im_q >= dsh_q);

  // signed quotients before clamping
  always_comb begin
    qe_re = $signed(XW'(q_re_q));
    qe_im = $signed(XW'(q_im_q));
    if (neg_re_q) qe_re = -qe_re;
    if (neg_im_q) qe_im = -qe_im;
  end

  // sequencer, divider registers and result selection
  always_comb begin
    state_d  = state_q;
    rem_re_d = rem_re_q;
    rem_im_d = rem_im_q;
    dsh_d    = dsh_q;
    q_re_d   = q_re_q;
    q_im_d   = q_im_q;
    neg_re_d = neg_re_q;
    neg_im_d = neg_im_q;
    ovp_re_d = ovp_re_q;
    ovp_im_d = ovp_im_q;
    cnt_d    = cnt_q;
    load     = 1'b0;
    s_re     = '0;
    s_im     = '0;
    out_cmp_d = 1'b0;
    out_st_d  = ST_OK;
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          case (it.op)
            OP_ADD: begin
              s_re = sat_f(XW'(it.a_re) + XW'(it.b_re));
              s_im = sat_f(XW'(it.a_im) + XW'(it.b_im));
              load = 1'b1;
            end
            OP_SUB: begin
              s_re = sat_f(XW'(it.a_re) - XW'(it.b_re));
              s_im = sat_f(XW'(it.a_im) - XW'(it.b_im));
              load = 1'b1;
            end
            OP_MUL:  state_d = BK_MUL;
            OP_DIV:  state_d = BK_DSET;
            OP_DIVZ: begin
              out_st_d = ST_DIVZ;
              load     = 1'b1;
            end
            OP_CMP: begin
              out_cmp_d = cmp;
              load      = 1'b1;
            end
            default: load = 1'b1;
          endcase
        end
      end
      BK_MUL: begin
        if (out_free) begin
          s_re    = sat_f((XW'(p_rr_q) - XW'(p_ii_q)) >>> FRAC_BITS);
          s_im    = sat_f((XW'(p_ri_q) + XW'(p_ir_q)) >>> FRAC_BITS);
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_DSET: begin
        rem_re_d = n_re;
        rem_im_d = n_im;
        dsh_d    = CW'(den) << (QB - 1);
        neg_re_d = x_re[XW-1];
        neg_im_d = x_im[XW-1];
        ovp_re_d = (n_re >= den_top);
        ovp_im_d = (n_im >= den_top);
        q_re_d   = '0;
        q_im_d   = '0;
        cnt_d    = KW'(QB);
        state_d  = BK_DRUN;
      end
      BK_DRUN: begin
        if (ge_re) rem_re_d = rem_re_q - dsh_q;
        if (ge_im) rem_im_d = rem_im_q - dsh_q;
        q_re_d  = {q_re_q[QB-2:0], ge_re};
        q_im_d  = {q_im_q[QB-2:0], ge_im};
        dsh_d   = dsh_q >> 1;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == KW'(1)) state_d = BK_DFIN;
      end
      BK_DFIN: begin
        if (out_free) begin
          s_re = ovp_re_q ? {1'b1, (neg_re_q ? MIN_W : MAX_W)} : sat_f(qe_re);
          s_im = ovp_im_q ? {1'b1, (neg_im_q ? MIN_W : MAX_W)} : sat_f(qe_im);
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    if (s_re[W] || s_im[W]) out_st_d = ST_OVF;
    out_re_d = s_re[W-1:0];
    out_im_d = s_im[W-1:0];
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_re_q <= rem_re_d;
    rem_im_q <= rem_im_d;
    dsh_q    <= dsh_d;
    q_re_q   <= q_re_d;
    q_im_q   <= q_im_d;
    neg_re_q <= neg_re_d;
    neg_im_q <= neg_im_d;
    ovp_re_q <= ovp_re_d;
    ovp_im_q <= ovp_im_d;
    if (load) begin
      out_re_q  <= out_re_d;
      out_im_q  <= out_im_d;
      out_cmp_q <= out_cmp_d;
      out_st_q  <= out_st_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_re       = out_re_q;
  assign out_o.out_im       = out_im_q;
  assign out_o.compare_true = out_cmp_q;
  assign out_o.status       = out_st_q;

  ap_drun_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DRUN |-> cnt_q != '0)
    else $error("divider running with empty bit count");

  ap_drun_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DRUN && cnt_q == KW'(1)) |=> state_q == BK_DFIN)
    else $error("divider did not finish after last bit");

  ap_cmp_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_cmp_q && out_st_q != ST_OK))
    else $error("compare result with nonzero status");

  ap_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q == ST_DIVZ) |-> (out_re_q == '0 && out_im_q == '0))
    else $error("division by zero with nonzero result");

endmodule
`default_nettype wire

// File: sv/complex_arithmetic_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top: fixed-point complex ALU
// Add, subtract, multiply, divide and part-wise compare of two complex
// operands in signed fixed point, with saturation and status.
//
//   channel  dir  payload                                   transfer when
//   in_i     in   mode, a_re, a_im, b_re, b_im              valid && ready
//   out_o    out  out_re, out_im, compare_true, status      valid && ready
//
// Add, subtract, compare, division by zero: one item per cycle unless out_o
// stalls or the back end is busy. Multiply: product register, then sum/clamp.
// Divide: product register, setup, then the restoring divider (one quotient
// bit per cycle). A two-entry queue lets the front keep taking items while
// the back end works; the output register holds a result while out_o stalls.
// Reset clears the queue, sequencer and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  import cau_pkg::*;

  localparam int ITEM_W = $bits(op_e) + 4 + 4 * WORD_WIDTH;

  logic              push_valid, push_ready, pop_valid, pop_ready;
  logic [ITEM_W-1:0] push_data, pop_data;

  cau_front #(
    .WORD_WIDTH (WORD_WIDTH),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  cau_queue #(
    .DATA_W (ITEM_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  cau_back #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/complex_arithmetic_unit_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top_test: self-checking bench of the complex ALU
// Feeds directed corner operands and random items through the operand
// channel in bursts. Each transfer is checked in order against a 128-bit
// exact model of add, sub, mul, div and part-wise compare.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top_test;
  import cau_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam logic [3:0] MODE_UNUSED = 4'd10;
  localparam int HOLD_AT   = 400;
  localparam int HOLD_LEN  = 300;
  localparam int N_RANDOM  = 1725;

  typedef struct {
    logic [3:0]          mode;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;
    bit                  drain;  // wait for all results before sending
  } operands_t;

  typedef struct {
    logic signed [W-1:0] out_re;
    logic signed [W-1:0] out_im;
    logic                compare_true;
    logic [1:0]          status;
  } alu_result_t;

  logic clk_i;
  logic rst_ni;

  cau_in_if  #(.WORD_WIDTH(W)) in_ch ();
  cau_out_if #(.WORD_WIDTH(W)) out_ch ();

  complex_arithmetic_unit_top #(.WORD_WIDTH(W), .FRAC_BITS(F)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  operands_t   pending_ops[$];
  alu_result_t expected_results[$];
  int          errors = 0;
  int          results_seen = 0;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // clamp an exact value to the word range
  function automatic logic signed [W-1:0] clamp_word(input logic signed [127:0] x,
                                                     inout bit ovf);
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = (128'sd1 <<< (W - 1)) - 128'sd1;
    lo_lim = -(128'sd1 <<< (W - 1));
    if (x > hi_lim) begin
      ovf = 1'b1;
      return hi_lim[W-1:0];
    end
    if (x < lo_lim) begin
      ovf = 1'b1;
      return lo_lim[W-1:0];
    end
    return x[W-1:0];
  endfunction

  // exact complex ALU result of one operand set
  function automatic alu_result_t alu_predict(input operands_t op);
    logic signed [127:0] ar, ai, br, bi, xr, xi, den;
    alu_result_t r;
    bit ovf;
    ar = op.a_re;
    ai = op.a_im;
    br = op.b_re;
    bi = op.b_im;
    ovf = 1'b0;
    r = '{default: '0};
    case (op.mode)
      MODE_ADD: begin
        r.out_re = clamp_word(ar + br, ovf);
        r.out_im = clamp_word(ai + bi, ovf);
      end
      MODE_SUB: begin
        r.out_re = clamp_word(ar - br, ovf);
        r.out_im = clamp_word(ai - bi, ovf);
      end
      MODE_MUL: begin
        xr = ar * br - ai * bi;
        xi = ar * bi + ai * br;
        r.out_re = clamp_word(xr >>> F, ovf);
        r.out_im = clamp_word(xi >>> F, ovf);
      end
      MODE_DIV: begin
        if (br == 0 && bi == 0) begin
          r.status = ST_DIVZ;
        end else begin
          den = br * br + bi * bi;
          xr = ar * br + ai * bi;
          xi = ai * br - ar * bi;
          // signed division truncates toward zero
          r.out_re = clamp_word((xr <<< F) / den, ovf);
          r.out_im = clamp_word((xi <<< F) / den, ovf);
        end
      end
      MODE_EQ: r.compare_true = (op.a_re == op.b_re) && (op.a_im == op.b_im);
      MODE_NE: r.compare_true = (op.a_re != op.b_re) || (op.a_im != op.b_im);
      MODE_LE: r.compare_true = (op.a_re <= op.b_re) && (op.a_im <= op.b_im);
      MODE_GE: r.compare_true = (op.a_re >= op.b_re) && (op.a_im >= op.b_im);
      MODE_LT: r.compare_true = (op.a_re < op.b_re) && (op.a_im < op.b_im);
      MODE_GT: r.compare_true = (op.a_re > op.b_re) && (op.a_im > op.b_im);
      default: ;
    endcase
    if (ovf) r.status = ST_OVF;
    return r;
  endfunction

  // random operand part: full range, small, extreme, zero or plus/minus one
  function automatic logic signed [W-1:0] rand_part();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return $urandom();
      4, 5:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      6:          return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      7:          return 0;
      8:          return ($urandom_range(0, 1)) ? 32'sh00010000 : -32'sh00010000;
      default:    return $signed($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  function automatic operands_t make_op(logic [3:0] m, logic signed [W-1:0] ar,
                                        logic signed [W-1:0] ai,
                                        logic signed [W-1:0] br,
                                        logic signed [W-1:0] bi);
    operands_t op;
    op = '{mode: m, a_re: ar, a_im: ai, b_re: br, b_im: bi, drain: 1'b0};
    return op;
  endfunction

  // driver: bursts of transfers with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode  <= '0;
      in_ch.a_re  <= '0;
      in_ch.a_im  <= '0;
      in_ch.b_re  <= '0;
      in_ch.b_im  <= '0;
      burst_left  = 1;
      gap_left    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(alu_predict(make_op(in_ch.mode, in_ch.a_re,
                                   in_ch.a_im, in_ch.b_re, in_ch.b_im)));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0 &&
                     (!pending_ops[0].drain || expected_results.size() == 0)) begin
          in_ch.valid <= 1'b1;
          in_ch.mode  <= pending_ops[0].mode;
          in_ch.a_re  <= pending_ops[0].a_re;
          in_ch.a_im  <= pending_ops[0].a_im;
          in_ch.b_re  <= pending_ops[0].b_re;
          in_ch.b_im  <= pending_ops[0].b_im;
          void'(pending_ops.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  int stall_phase;
  int hold_left;
  bit held_once;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_phase  = 0;
      hold_left    = 0;
      held_once    = 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 256;
      if (!held_once && results_seen >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_phase < 96) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 9) < 6);
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  alu_result_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.out_re !== want.out_re) begin
          $error("out_re expected %0d actual %0d", want.out_re, out_ch.out_re);
          errors++;
        end
        if (out_ch.out_im !== want.out_im) begin
          $error("out_im expected %0d actual %0d", want.out_im, out_ch.out_im);
          errors++;
        end
        if (out_ch.compare_true !== want.compare_true) begin
          $error("compare_true expected %0d actual %0d", want.compare_true,
                 out_ch.compare_true);
          errors++;
        end
        if (out_ch.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  operands_t op;
  int k;
  initial begin
    rst_ni = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = '0;
    in_ch.a_re   = '0;
    in_ch.a_im   = '0;
    in_ch.b_re   = '0;
    in_ch.b_im   = '0;
    out_ch.ready = 1'b0;

    // directed corners
    pending_ops.push_back(make_op(MODE_ADD, 32'sh7fffffff, 32'sh80000000,
                                  32'sh00000001, -32'sh1));
    pending_ops.push_back(make_op(MODE_ADD, 32'sh00010000, 32'sh00020000,
                                  32'sh00030000, -32'sh00010000));
    pending_ops.push_back(make_op(MODE_SUB, 32'sh80000000, 32'sh7fffffff,
                                  32'sh00000001, -32'sh1));
    pending_ops.push_back(make_op(MODE_SUB, 32'sh7fffffff, 32'sh80000000,
                                  32'sh7fffffff, 32'sh80000000));
    pending_ops.push_back(make_op(MODE_MUL, 32'sh00020000, 32'sh00010000,
                                  32'sh00030000, -32'sh00010000));
    pending_ops.push_back(make_op(MODE_MUL, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sh80000000));
    pending_ops.push_back(make_op(MODE_MUL, -32'sh1, 32'sh0, 32'sh1, 32'sh0));
    pending_ops.push_back(make_op(MODE_DIV, 32'sh00010000, 32'sh0, 32'sh0, 32'sh0));
    pending_ops.push_back(make_op(MODE_DIV, 32'sh00060000, 32'sh00020000,
                                  32'sh00020000, 32'sh0));
    pending_ops.push_back(make_op(MODE_DIV, 32'sh7fffffff, 32'sh7fffffff,
                                  32'sh1, 32'sh0));
    pending_ops.push_back(make_op(MODE_DIV, -32'sh00010000, 32'sh00010000,
                                  32'sh00030000, 32'sh00070000));
    pending_ops.push_back(make_op(MODE_DIV, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sh80000000));
    pending_ops.push_back(make_op(MODE_EQ, 32'sh5, -32'sh5, 32'sh5, -32'sh5));
    pending_ops.push_back(make_op(MODE_EQ, 32'sh5, -32'sh5, 32'sh5, 32'sh5));
    pending_ops.push_back(make_op(MODE_NE, 32'sh5, -32'sh5, 32'sh5, -32'sh5));
    pending_ops.push_back(make_op(MODE_NE, 32'sh5, -32'sh5, 32'sh5, 32'sh4));
    pending_ops.push_back(make_op(MODE_LE, 32'sh80000000, 32'sh3, 32'sh7fffffff, 32'sh3));
    pending_ops.push_back(make_op(MODE_GE, 32'sh7fffffff, 32'sh3, 32'sh80000000, 32'sh4));
    pending_ops.push_back(make_op(MODE_LT, -32'sh2, -32'sh2, -32'sh1, -32'sh1));
    pending_ops.push_back(make_op(MODE_GT, 32'sh1, 32'sh1, 32'sh1, 32'sh0));
    for (k = 0; k < 6; k++)
      pending_ops.push_back(make_op(MODE_UNUSED + k[3:0], 32'sh7fffffff, -32'sh1,
                                    32'sh0, 32'sh0));

    // random part
    for (k = 0; k < N_RANDOM; k++) begin
      op.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
      op.a_re = rand_part();
      op.a_im = rand_part();
      op.b_re = rand_part();
      op.b_im = ($urandom_range(0, 4) == 0) ? '0 : rand_part();
      case ($urandom_range(0, 7))
        0: begin
          op.b_re = op.a_re;
          op.b_im = op.a_im;
        end
        1: op.b_re = op.a_re;
        2: if (op.mode == MODE_DIV) begin
          op.b_re = '0;
          op.b_im = '0;
        end
        default: ;
      endcase
      // pause the sender until the unit has drained, at the start and mid-run
      op.drain = (k == 0) || (k == N_RANDOM / 2);
      pending_ops.push_back(op);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_ops.size() == 0);
    @(posedge clk_i);
    while (in_ch.valid) @(posedge clk_i);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
